// ===== rtl/xtea_block_cipher_core_macros.svh =====
// Assertion macros shared by the XTEA core files.
// Needs nothing else; included by the modules that carry assertions.
`ifndef XTEA_BLOCK_CIPHER_CORE_MACROS_SVH
`define XTEA_BLOCK_CIPHER_CORE_MACROS_SVH

// Same-cycle implication under asynchronous active-low reset.
`define XTEA_ASSERT_IMP(lbl, c, r, a, b) \
	lbl: assert property (@(posedge c) disable iff (!r) (a) |-> (b)) \
		else $error("xtea assertion failed");

// Next-cycle implication.
`define XTEA_ASSERT_NEXT(lbl, c, r, a, b) \
	lbl: assert property (@(posedge c) disable iff (!r) (a) |=> (b)) \
		else $error("xtea assertion failed");

// Implication after a fixed number of cycles.
`define XTEA_ASSERT_DLY(lbl, c, r, a, n, b) \
	lbl: assert property (@(posedge c) disable iff (!r) (a) |-> ##(n) (b)) \
		else $error("xtea assertion failed");

`endif

// ===== rtl/xtea_pkg.sv =====
// Types, constants and the round function of the XTEA core.
// Depends on nothing; imported by every module of the core.
package xtea_pkg;

	localparam int XTEA_MAX_ROUNDS = 64;
	localparam logic [31:0] XTEA_DELTA = 32'h9E3779B9;
	localparam logic [6:0] XTEA_RC_RESET = 7'd32;
	localparam logic [31:0] XTEA_SUM_RESET = 32'(64'(XTEA_DELTA) * 64'(XTEA_RC_RESET));
	localparam int XTEA_ADDR_W = 5;

	typedef enum logic [2:0] {
		REG_KEY0 = 3'd0,
		REG_KEY1 = 3'd1,
		REG_KEY2 = 3'd2,
		REG_KEY3 = 3'd3,
		REG_ROUNDS = 3'd4
	} xtea_reg_t;

	typedef struct packed {
		logic kind;
		logic [31:0] block_word_zero;
		logic [31:0] block_word_one;
	} xtea_in_t;

	typedef struct packed {
		logic [31:0] out_word_zero;
		logic [31:0] out_word_one;
	} xtea_out_t;

	typedef struct packed {
		logic valid;
		logic kind;
		logic [31:0] v0;
		logic [31:0] v1;
		logic [31:0] sum;
	} xtea_stage_t;

	function automatic logic [31:0] xtea_f(input logic [31:0] x, input logic [31:0] sum,
			input logic [31:0] k);
		logic [31:0] mix;
		mix = ((x << 4) ^ (x >> 5)) + x;
		return mix ^ (sum + k);
	endfunction

endpackage

// ===== rtl/xtea_cfg.sv =====
// Configuration register bank of the XTEA core behind an APB-style port.
// Depends on xtea_pkg; supplies the key, the limited round count and the start sum.
module xtea_cfg import xtea_pkg::*; #(
	parameter int MAX_ROUNDS = XTEA_MAX_ROUNDS,
	localparam int NW = $clog2(MAX_ROUNDS + 1)
) (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [XTEA_ADDR_W-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	output logic [3:0][31:0] key,
	output logic [NW-1:0] rounds,
	output logic [31:0] sum_init
);

	logic [3:0][31:0] key_q;
	logic [6:0] rc_q;
	logic [31:0] sum_init_q;
	logic [31+NW:0] prod;
	logic wr_en;
	xtea_reg_t idx;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;
	assign idx = xtea_reg_t'(paddr[XTEA_ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
			rc_q <= XTEA_RC_RESET;
		end else if (wr_en) begin
			unique case (idx)
				REG_KEY0: key_q[0] <= pwdata;
				REG_KEY1: key_q[1] <= pwdata;
				REG_KEY2: key_q[2] <= pwdata;
				REG_KEY3: key_q[3] <= pwdata;
				REG_ROUNDS: rc_q <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (rc_q == 7'd0) begin
			rounds = NW'(1);
		end else if (32'(rc_q) > 32'(MAX_ROUNDS)) begin
			rounds = NW'(MAX_ROUNDS);
		end else begin
			rounds = NW'(rc_q);
		end
	end

	assign prod = (32 + NW)'(XTEA_DELTA) * (32 + NW)'(rounds);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_init_q <= XTEA_SUM_RESET;
		end else begin
			sum_init_q <= prod[31:0];
		end
	end

	always_comb begin
		unique case (idx)
			REG_KEY0: prdata = key_q[0];
			REG_KEY1: prdata = key_q[1];
			REG_KEY2: prdata = key_q[2];
			REG_KEY3: prdata = key_q[3];
			REG_ROUNDS: prdata = 32'(rc_q);
			default: prdata = '0;
		endcase
	end

	assign key = key_q;
	assign sum_init = sum_init_q;

endmodule

// ===== rtl/xtea_half.sv =====
// One half-round pipeline stage of the XTEA core, for both directions.
// Depends on xtea_pkg; chained by the top level, one instance per half-round.
module xtea_half import xtea_pkg::*; #(
	parameter int MAX_ROUNDS = XTEA_MAX_ROUNDS,
	parameter int IDX = 0,
	localparam int NW = $clog2(MAX_ROUNDS + 1)
) (
	input logic clk,
	input logic arst_n,
	input logic [3:0][31:0] key,
	input logic [NW-1:0] rounds,
	input xtea_stage_t stg_in,
	output xtea_stage_t stg_out
);

	localparam int RND = IDX / 2;
	localparam bit SECOND = (IDX % 2) == 1;

	xtea_stage_t stg_s1;
	xtea_stage_t nxt;
	logic act;
	logic hi_sel;
	logic [31:0] x;
	logic [31:0] t;
	logic [31:0] upd;

	assign act = stg_in.valid && (int'(rounds) > RND);
	assign hi_sel = SECOND ^ stg_in.kind;
	assign x = hi_sel ? stg_in.v0 : stg_in.v1;
	assign t = xtea_f(x, stg_in.sum, key[hi_sel ? stg_in.sum[12:11] : stg_in.sum[1:0]]);

	always_comb begin
		nxt = stg_in;
		if (hi_sel) begin
			upd = stg_in.kind ? stg_in.v1 - t : stg_in.v1 + t;
		end else begin
			upd = stg_in.kind ? stg_in.v0 - t : stg_in.v0 + t;
		end
		if (act) begin
			if (hi_sel) begin
				nxt.v1 = upd;
			end else begin
				nxt.v0 = upd;
			end
			if (!SECOND) begin
				nxt.sum = stg_in.kind ? stg_in.sum - XTEA_DELTA : stg_in.sum + XTEA_DELTA;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_s1 <= '0;
		end else begin
			stg_s1 <= nxt;
		end
	end

	assign stg_out = stg_s1;

endmodule

// ===== rtl/xtea_block_cipher_core.sv =====
// XTEA block cipher core: a fully unrolled pipeline of one stage per half-round.
// A word taken with start is registered at entry, then in each half-round stage, and
// is on result with done high; one word per cycle, set by the half-round stage chain.
// busy is always low and the receiver cannot stall, so the pipeline never holds.
// Reset clears all valid bits, the key to zero and the round count to 32.
// Depends on xtea_pkg, xtea_cfg, xtea_half and the assertion macro header.
`include "xtea_block_cipher_core_macros.svh"
module xtea_block_cipher_core import xtea_pkg::*; #(
	parameter int MAX_ROUNDS = XTEA_MAX_ROUNDS
) (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [XTEA_ADDR_W-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input logic start,
	output logic busy,
	input xtea_in_t blk,
	output logic done,
	output xtea_out_t result
);

	localparam int NW = $clog2(MAX_ROUNDS + 1);
	localparam int NSTG = 2 * MAX_ROUNDS;

	logic [3:0][31:0] key;
	logic [NW-1:0] rounds;
	logic [31:0] sum_init;
	logic ent_valid_s1;
	xtea_in_t ent_s1;
	xtea_stage_t stg [0:NSTG];

	xtea_cfg #(.MAX_ROUNDS(MAX_ROUNDS)) u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.key(key),
		.rounds(rounds),
		.sum_init(sum_init)
	);

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_valid_s1 <= 1'b0;
		end else begin
			ent_valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			ent_s1 <= blk;
		end
	end

	always_comb begin
		stg[0].valid = ent_valid_s1;
		stg[0].kind = ent_s1.kind;
		stg[0].v0 = ent_s1.block_word_zero;
		stg[0].v1 = ent_s1.block_word_one;
		stg[0].sum = ent_s1.kind ? sum_init : 32'd0;
	end

	for (genvar g = 0; g < NSTG; g++) begin : g_stage
		xtea_half #(.MAX_ROUNDS(MAX_ROUNDS), .IDX(g)) u_half (
			.clk(clk),
			.arst_n(arst_n),
			.key(key),
			.rounds(rounds),
			.stg_in(stg[g]),
			.stg_out(stg[g + 1])
		);
	end

	assign done = stg[NSTG].valid;
	assign result.out_word_zero = stg[NSTG].v0;
	assign result.out_word_one = stg[NSTG].v1;

	`XTEA_ASSERT_NEXT(a_entry, clk, arst_n, start, ent_valid_s1)
	`XTEA_ASSERT_DLY(a_flow, clk, arst_n, ent_valid_s1, NSTG, done)
	`XTEA_ASSERT_DLY(a_no_spurious, clk, arst_n, !ent_valid_s1, NSTG, !done)
	`XTEA_ASSERT_IMP(a_rounds, clk, arst_n, 1'b1, rounds != '0 && int'(rounds) <= MAX_ROUNDS)

endmodule

// ===== tb/tb_xtea_block_cipher_core.sv =====
// Self-checking testbench for the XTEA block cipher core: blocks are enciphered and
// deciphered under several keys and round settings and compared with a local model.
// Depends on xtea_pkg and xtea_block_cipher_core.
`timescale 1ns / 1ps
module tb_xtea_block_cipher_core;
	import xtea_pkg::*;

	localparam int MAX_ROUNDS = XTEA_MAX_ROUNDS;
	localparam logic KIND_ENCRYPT = 1'b0;
	localparam logic KIND_DECRYPT = 1'b1;
	localparam logic [2:0] REG_SPARE_FIRST = 3'd5;
	localparam logic [2:0] REG_SPARE_LAST = 3'd7;
	localparam int RANDOM_PHASES = 9;
	localparam int WORDS_PER_PHASE = 150;

	typedef struct {
		xtea_in_t word;
		int gap;
	} pending_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [XTEA_ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic start = 1'b0;
	logic busy;
	xtea_in_t blk = '0;
	logic done;
	xtea_out_t result;

	pending_t pending_blocks[$];
	xtea_out_t expected_blocks[$];
	logic [31:0] key_model[4] = '{32'd0, 32'd0, 32'd0, 32'd0};
	logic [6:0] rounds_model = XTEA_RC_RESET;
	int idle_cycles = 0;
	int mismatch_count = 0;

	xtea_block_cipher_core #(.MAX_ROUNDS(MAX_ROUNDS)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.start(start),
		.busy(busy),
		.blk(blk),
		.done(done),
		.result(result)
	);

	always #5 clk = ~clk;

	function automatic logic [31:0] feistel_mix(input logic [31:0] x);
		return ((x << 4) ^ (x >> 5)) + x;
	endfunction

	function automatic xtea_out_t cipher_block(input xtea_in_t w);
		logic [31:0] v0;
		logic [31:0] v1;
		logic [31:0] sum;
		int n;
		xtea_out_t r;
		n = int'(rounds_model);
		if (n < 1)
			n = 1;
		if (n > MAX_ROUNDS)
			n = MAX_ROUNDS;
		v0 = w.block_word_zero;
		v1 = w.block_word_one;
		if (w.kind == KIND_ENCRYPT) begin
			sum = '0;
			for (int i = 0; i < n; i++) begin
				v0 += feistel_mix(v1) ^ (sum + key_model[sum[1:0]]);
				sum += XTEA_DELTA;
				v1 += feistel_mix(v0) ^ (sum + key_model[sum[12:11]]);
			end
		end else begin
			sum = XTEA_DELTA * 32'(n);
			for (int i = 0; i < n; i++) begin
				v1 -= feistel_mix(v0) ^ (sum + key_model[sum[12:11]]);
				sum -= XTEA_DELTA;
				v0 -= feistel_mix(v1) ^ (sum + key_model[sum[1:0]]);
			end
		end
		r.out_word_zero = v0;
		r.out_word_one = v1;
		return r;
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 9))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx < REG_ROUNDS)
			key_model[idx[1:0]] = value;
		else if (idx == REG_ROUNDS)
			rounds_model = value[6:0];
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic queue_block(input logic kind, input logic [31:0] w0, input logic [31:0] w1,
			input int gap);
		pending_t p;
		p.word.kind = kind;
		p.word.block_word_zero = w0;
		p.word.block_word_one = w1;
		p.gap = gap;
		pending_blocks.push_back(p);
	endtask

	task automatic drain();
		do @(negedge clk); while (pending_blocks.size() != 0 || start || expected_blocks.size() != 0);
	endtask

	task automatic queue_directed();
		logic kind_sel;
		for (int k = 0; k < 2; k++) begin
			kind_sel = (k == 0) ? KIND_ENCRYPT : KIND_DECRYPT;
			queue_block(kind_sel, 32'h0000_0000, 32'h0000_0000, $urandom_range(0, 7));
			queue_block(kind_sel, 32'hFFFF_FFFF, 32'hFFFF_FFFF, $urandom_range(0, 7));
			queue_block(kind_sel, 32'h8000_0000, 32'h0000_0001, $urandom_range(0, 7));
			queue_block(kind_sel, 32'h0000_0001, 32'h8000_0000, $urandom_range(0, 7));
			queue_block(kind_sel, 32'hAAAA_AAAA, 32'h5555_5555, $urandom_range(0, 7));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		pending_t nxt;
		if (!arst_n) begin
			start <= 1'b0;
			idle_cycles <= 0;
		end else begin
			if (start && !busy)
				expected_blocks.push_back(cipher_block(blk));
			if (start && busy) begin
			end else if (pending_blocks.size() != 0 && idle_cycles >= pending_blocks[0].gap) begin
				nxt = pending_blocks.pop_front();
				blk <= nxt.word;
				start <= 1'b1;
				idle_cycles <= 0;
			end else begin
				start <= 1'b0;
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	always @(posedge clk) begin
		xtea_out_t want;
		if (arst_n && done) begin
			if (expected_blocks.size() == 0) begin
				$display("%0t: unexpected word, expected none, got %h %h", $time,
					result.out_word_zero, result.out_word_one);
				mismatch_count++;
			end else begin
				want = expected_blocks.pop_front();
				if (result.out_word_zero !== want.out_word_zero) begin
					$display("%0t: out_word_zero expected %h, got %h", $time,
						want.out_word_zero, result.out_word_zero);
					mismatch_count++;
				end
				if (result.out_word_one !== want.out_word_one) begin
					$display("%0t: out_word_one expected %h, got %h", $time,
						want.out_word_one, result.out_word_one);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		int max_gap;
		logic [6:0] rounds;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		queue_directed();
		drain();
		write_reg(REG_KEY0, 32'h0001_0203);
		write_reg(REG_KEY1, 32'h0405_0607);
		write_reg(REG_KEY2, 32'h0809_0A0B);
		write_reg(REG_KEY3, 32'h0C0D_0E0F);
		@(negedge clk);
		queue_directed();
		drain();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: rounds = 7'(MAX_ROUNDS);
				1: rounds = 7'd1;
				2: rounds = 7'd0;
				3: rounds = 7'd127;
				4: rounds = 7'(MAX_ROUNDS + 1);
				default: rounds = 7'($urandom_range(0, 127));
			endcase
			if (p == 1) begin
				write_reg(REG_KEY0, 32'hFFFF_FFFF);
				write_reg(REG_KEY1, 32'hFFFF_FFFF);
				write_reg(REG_KEY2, 32'hFFFF_FFFF);
				write_reg(REG_KEY3, 32'hFFFF_FFFF);
			end else begin
				write_reg(REG_KEY0, rand_word());
				write_reg(REG_KEY1, rand_word());
				write_reg(REG_KEY2, rand_word());
				write_reg(REG_KEY3, rand_word());
			end
			write_reg(REG_ROUNDS, {25'($urandom), rounds});
			if (p == 5) begin
				for (int s = REG_SPARE_FIRST; s <= REG_SPARE_LAST; s++)
					write_reg(3'(s), $urandom);
			end
			max_gap = (p % 3 == 1) ? 0 : 7;
			@(negedge clk);
			for (int i = 0; i < WORDS_PER_PHASE; i++)
				queue_block(1'($urandom), rand_word(), rand_word(), $urandom_range(0, max_gap));
			drain();
		end

		repeat (2 * MAX_ROUNDS + 8) @(posedge clk);
		if (expected_blocks.size() != 0) begin
			$display("%0t: %0d expected words never arrived", $time, expected_blocks.size());
			mismatch_count++;
		end
		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== xtea_block_cipher_core.f =====
+incdir+rtl
rtl/xtea_pkg.sv
rtl/xtea_cfg.sv
rtl/xtea_half.sv
rtl/xtea_block_cipher_core.sv
tb/tb_xtea_block_cipher_core.sv
